>>> hdl/mssc_pkg.sv
// Shared types, constants and small decode functions for the multiplexed
// seven-segment clock. No dependencies; every other file in hdl uses it.
`timescale 1ns / 1ps

package mssc_pkg;

    // Display geometry and field widths.
    localparam int NUM_DIGITS = 4;
    localparam int DSEL_W     = $clog2(NUM_DIGITS);
    localparam int DIG_W      = 4;
    localparam int SEG_W      = 7;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int TPS_W      = 10;
    localparam int TPD_W      = 8;
    localparam int SCAN_W     = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPD = 1'b1;

    // Reset values.
    localparam logic [TPS_W-1:0]  TPS_RST      = 10'd100;
    localparam logic [TPD_W-1:0]  TPD_RST      = 8'd25;
    localparam logic [HOUR_W-1:0] HOURS_RST    = 5'd15;
    localparam logic [MIN_W-1:0]  MINUTES_RST  = 6'd8;
    localparam logic [SEC_W-1:0]  SECONDS_RST  = 6'd50;
    localparam logic [TPS_W-1:0]  SEC_LEFT_RST = 10'd100;
    localparam logic [SCAN_W-1:0] SCAN_RST     = 10'd100;

    // Wrap limits of the clock counters.
    localparam int SECS_PER_MIN  = 60;
    localparam int MINS_PER_HOUR = 60;
    localparam int HOURS_PER_DAY = 24;

    typedef logic [NUM_DIGITS-1:0][DIG_W-1:0] digits_t;

    // What the display decoder needs for one item.
    typedef struct packed {
        logic [SCAN_W-1:0] scan;
        logic [TPD_W-1:0]  tpd;
        digits_t           digits;
    } view_t;

    // One result item.
    typedef struct packed {
        logic [SEG_W-1:0]      segments;
        logic [NUM_DIGITS-1:0] digit_enables;
        logic                  blink;
        logic [HOUR_W-1:0]     hours;
        logic [MIN_W-1:0]      minutes;
        logic [SEC_W-1:0]      seconds;
    } result_t;

    // Tens digit of a value below 60.
    function automatic logic [DIG_W-1:0] tens_of(input logic [5:0] v);
        logic [DIG_W-1:0] t;
        if (v >= 6'd50)      t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    // Ones digit of a value below 60.
    function automatic logic [DIG_W-1:0] ones_of(input logic [5:0] v);
        logic [6:0] prod;
        logic [5:0] rem;
        prod = {3'b000, tens_of(v)} * 7'd10;
        rem  = v - prod[5:0];
        return rem[DIG_W-1:0];
    endfunction

    // Lit-segment mask, bit i set means segment i (a..g) is lit.
    function automatic logic [SEG_W-1:0] lit_mask(input logic [DIG_W-1:0] code);
        logic [SEG_W-1:0] m;
        case (code)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

    // Active-low segment levels; codes above nine come out blank.
    function automatic logic [SEG_W-1:0] decode_segments(input logic [DIG_W-1:0] code);
        return ~lit_mask(code);
    endfunction

endpackage

>>> hdl/mssc_core.sv
// Timekeeping state of the seven-segment clock: configuration registers,
// second and scan counters, HH:MM:SS counters, blink level and digit store.
// Depends on mssc_pkg.
`timescale 1ns / 1ps

module mssc_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mssc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mssc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             step_tick,
    output mssc_pkg::view_t                  view,
    output logic                             blink_next,
    output logic [mssc_pkg::HOUR_W-1:0]      hours_next,
    output logic [mssc_pkg::MIN_W-1:0]       minutes_next,
    output logic [mssc_pkg::SEC_W-1:0]       seconds_next
);

    logic [mssc_pkg::TPS_W-1:0]  tps_reg;
    logic [mssc_pkg::TPD_W-1:0]  tpd_reg;
    logic [mssc_pkg::HOUR_W-1:0] hours_reg;
    logic [mssc_pkg::MIN_W-1:0]  minutes_reg;
    logic [mssc_pkg::SEC_W-1:0]  seconds_reg;
    logic [mssc_pkg::TPS_W-1:0]  sec_left_reg;
    logic [mssc_pkg::TPS_W-1:0]  sec_left_next;
    logic [mssc_pkg::SCAN_W-1:0] scan_reg;
    logic [mssc_pkg::SCAN_W-1:0] scan_next;
    mssc_pkg::digits_t           store_reg;
    mssc_pkg::digits_t           store_next;
    logic                        blink_reg;

    logic [mssc_pkg::TPS_W-1:0]  tps_eff;
    logic [mssc_pkg::TPD_W-1:0]  tpd_eff;
    logic [mssc_pkg::SCAN_W-1:0] scan_reload;
    logic [mssc_pkg::SCAN_W-1:0] scan_base;
    logic [mssc_pkg::SCAN_W-1:0] scan_dec;
    logic                        sec_event;
    logic [mssc_pkg::SEC_W:0]    sec_inc;
    logic [mssc_pkg::MIN_W:0]    min_inc;
    logic [mssc_pkg::HOUR_W:0]   hour_inc;
    logic                        sec_wrap;
    logic                        min_wrap;
    logic [mssc_pkg::SEC_W-1:0]  sec_adv;
    logic [mssc_pkg::MIN_W-1:0]  min_adv;
    logic [mssc_pkg::HOUR_W-1:0] hour_adv;

    // A register value of zero behaves as one.
    assign tps_eff     = (tps_reg == '0) ? mssc_pkg::TPS_W'(1) : tps_reg;
    assign tpd_eff     = (tpd_reg == '0) ? mssc_pkg::TPD_W'(1) : tpd_reg;
    assign scan_reload = {tpd_eff, 2'b00};

    assign sec_event = step_tick && (sec_left_reg <= mssc_pkg::TPS_W'(1));

    always_comb
    begin
        if (!step_tick)
            sec_left_next = sec_left_reg;
        else if (sec_event)
            sec_left_next = tps_eff;
        else
            sec_left_next = sec_left_reg - mssc_pkg::TPS_W'(1);
    end

    // The display reads the count after this tick's decrement, before the
    // reload that keeps the stored count away from zero.
    assign scan_base = (scan_reg == '0) ? scan_reload : scan_reg;
    assign scan_dec  = scan_base - mssc_pkg::SCAN_W'(1);

    always_comb
    begin
        if (!step_tick)
            scan_next = scan_reg;
        else if (scan_dec == '0)
            scan_next = scan_reload;
        else
            scan_next = scan_dec;
    end

    // Seconds, minutes and hours with carries.
    always_comb
    begin
        sec_inc  = {1'b0, seconds_reg} + (mssc_pkg::SEC_W + 1)'(1);
        sec_wrap = sec_inc >= (mssc_pkg::SEC_W + 1)'(mssc_pkg::SECS_PER_MIN);
        sec_adv  = sec_wrap ? '0 : sec_inc[mssc_pkg::SEC_W-1:0];
        min_inc  = {1'b0, minutes_reg} + {{mssc_pkg::MIN_W{1'b0}}, sec_wrap};
        min_wrap = min_inc >= (mssc_pkg::MIN_W + 1)'(mssc_pkg::MINS_PER_HOUR);
        min_adv  = min_wrap ? '0 : min_inc[mssc_pkg::MIN_W-1:0];
        hour_inc = {1'b0, hours_reg} + {{mssc_pkg::HOUR_W{1'b0}}, min_wrap};
        if (hour_inc >= (mssc_pkg::HOUR_W + 1)'(mssc_pkg::HOURS_PER_DAY))
            hour_adv = '0;
        else
            hour_adv = hour_inc[mssc_pkg::HOUR_W-1:0];
    end

    assign seconds_next = sec_event ? sec_adv  : seconds_reg;
    assign minutes_next = sec_event ? min_adv  : minutes_reg;
    assign hours_next   = sec_event ? hour_adv : hours_reg;
    assign blink_next   = blink_reg ^ sec_event;

    always_comb
    begin
        store_next = store_reg;
        if (sec_event)
        begin
            store_next[0] = mssc_pkg::tens_of({1'b0, hour_adv});
            store_next[1] = mssc_pkg::ones_of({1'b0, hour_adv});
            store_next[2] = mssc_pkg::tens_of(min_adv);
            store_next[3] = mssc_pkg::ones_of(min_adv);
        end
    end

    assign view.scan   = step_tick ? scan_dec : scan_reg;
    assign view.tpd    = tpd_eff;
    assign view.digits = store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= mssc_pkg::TPS_RST;
            tpd_reg <= mssc_pkg::TPD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mssc_pkg::CFG_TPS: tps_reg <= cfg_data[mssc_pkg::TPS_W-1:0];
                mssc_pkg::CFG_TPD: tpd_reg <= cfg_data[mssc_pkg::TPD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hours_reg    <= mssc_pkg::HOURS_RST;
            minutes_reg  <= mssc_pkg::MINUTES_RST;
            seconds_reg  <= mssc_pkg::SECONDS_RST;
            sec_left_reg <= mssc_pkg::SEC_LEFT_RST;
            scan_reg     <= mssc_pkg::SCAN_RST;
            store_reg    <= '0;
            blink_reg    <= 1'b0;
        end
        else
        begin
            hours_reg    <= hours_next;
            minutes_reg  <= minutes_next;
            seconds_reg  <= seconds_next;
            sec_left_reg <= sec_left_next;
            scan_reg     <= scan_next;
            store_reg    <= store_next;
            blink_reg    <= blink_next;
        end
    end

    a_scan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg != '0)
        else $error("scan count rested at zero");

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        seconds_reg < mssc_pkg::SEC_W'(mssc_pkg::SECS_PER_MIN))
        else $error("seconds out of range");

    a_hour_carry: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(hours_reg) |-> (minutes_reg == '0 && seconds_reg == '0))
        else $error("hour changed without a minute carry");

endmodule

>>> hdl/mssc_disp.sv
// Display decode: picks the active digit from the scan count and turns it
// into active-low segment and digit-enable levels. Depends on mssc_pkg.
`timescale 1ns / 1ps

module mssc_disp (
    input  mssc_pkg::view_t                    view,
    output logic [mssc_pkg::SEG_W-1:0]         segments,
    output logic [mssc_pkg::NUM_DIGITS-1:0]    digit_enables
);

    logic [mssc_pkg::SCAN_W-1:0] thr1;
    logic [mssc_pkg::SCAN_W-1:0] thr2;
    logic [mssc_pkg::SCAN_W-1:0] thr3;
    logic [mssc_pkg::DSEL_W-1:0] quot;
    logic [mssc_pkg::DSEL_W-1:0] sel;

    // Scan count over ticks-per-digit, saturated at three, by comparison
    // against the first three multiples.
    assign thr1 = {2'b00, view.tpd};
    assign thr2 = {1'b0, view.tpd, 1'b0};
    assign thr3 = thr2 + thr1;

    always_comb
    begin
        if (view.scan >= thr3)      quot = mssc_pkg::DSEL_W'(3);
        else if (view.scan >= thr2) quot = mssc_pkg::DSEL_W'(2);
        else if (view.scan >= thr1) quot = mssc_pkg::DSEL_W'(1);
        else                        quot = mssc_pkg::DSEL_W'(0);
    end

    assign sel           = mssc_pkg::DSEL_W'(mssc_pkg::NUM_DIGITS - 1) - quot;
    assign digit_enables = ~(mssc_pkg::NUM_DIGITS'(1) << sel);
    assign segments      = mssc_pkg::decode_segments(view.digits[sel]);

endmodule

>>> hdl/mssc_obuf.sv
// Result register with a skid stage, so a new item can be taken while the
// previous result waits. Depends on mssc_pkg.
`timescale 1ns / 1ps

module mssc_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mssc_pkg::result_t res,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output mssc_pkg::result_t out_res
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    mssc_pkg::result_t out_res_reg;
    mssc_pkg::result_t skid_res_reg;
    logic              out_fire;

    assign out_fire  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_res_reg <= skid_res_reg;
        end
        else if (load)
        begin
            if (out_valid_reg && !out_fire)
                skid_res_reg <= res;
            else
                out_res_reg <= res;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while result register empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid stage did not drain on a taken result");

endmodule

>>> hdl/multiplexed_seven_segment_clock.sv
// Top level of the four-digit multiplexed seven-segment HH:MM clock.
// Depends on mssc_pkg, mssc_core, mssc_disp and mssc_obuf.
//
//   channel  direction  handshake              payload
//   -------  ---------  ---------------------  ---------------------------------
//   in       input      in_valid / in_stall    tick
//   out      output     out_valid / out_stall  segments, digit_enables, blink,
//                                              hours_now, minutes_now, seconds_now
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// Every accepted item produces exactly one result item, held in the result
// register or, while out_stall holds, in the skid stage. One item per cycle is
// sustained while out_stall stays low; the state update is combinational.
// Reset (rst_n low, asynchronous) sets the clock to 15:08:50, both counters to
// 100, the digit store to zeros and blink low; registers go to 100 and 25.
// When out_stall holds a result, one more item still enters through the skid
// stage; in_stall rises only while that stage is full.
`timescale 1ns / 1ps

module multiplexed_seven_segment_clock (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mssc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mssc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                tick,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mssc_pkg::SEG_W-1:0]          segments,
    output logic [mssc_pkg::NUM_DIGITS-1:0]     digit_enables,
    output logic                                blink,
    output logic [mssc_pkg::HOUR_W-1:0]         hours_now,
    output logic [mssc_pkg::MIN_W-1:0]          minutes_now,
    output logic [mssc_pkg::SEC_W-1:0]          seconds_now
);

    logic              in_fire;
    logic              step_tick;
    mssc_pkg::view_t   view;
    mssc_pkg::result_t res;
    mssc_pkg::result_t out_res;

    // An item is taken whenever the skid stage has room. Only a taken item
    // with its tick bit set moves the counters; a taken idle item just
    // reports the current display and time.
    assign in_fire   = in_valid && !in_stall;
    assign step_tick = in_fire && tick;

    // The core computes the post-tick time and the view of the display,
    // which uses the digit store as it stood before this tick's latch.
    mssc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step_tick    (step_tick),
        .view         (view),
        .blink_next   (res.blink),
        .hours_next   (res.hours),
        .minutes_next (res.minutes),
        .seconds_next (res.seconds)
    );

    mssc_disp u_disp (
        .view          (view),
        .segments      (res.segments),
        .digit_enables (res.digit_enables)
    );

    // The result register and skid stage decouple the two channels.
    mssc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .res       (res),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign segments      = out_res.segments;
    assign digit_enables = out_res.digit_enables;
    assign blink         = out_res.blink;
    assign hours_now     = out_res.hours;
    assign minutes_now   = out_res.minutes;
    assign seconds_now   = out_res.seconds;

endmodule
